>>> hdl/tnig_pkg.sv
// ----------------------------------------------------------------------------
// tnig_pkg: shared constants for the nearest-image gather
// Fixed formats, register indexes and the command codes of the queue entry.
// ----------------------------------------------------------------------------
`default_nettype none
package tnig_pkg;
    localparam int COMP_BITS  = 21;
    localparam int RECIP_FRAC = 17;
    localparam int CNT_BITS   = 8;
    localparam int REG_BITS   = 63;
    localparam int IDX_BITS   = 3;

    localparam logic [IDX_BITS-1:0] REG_BOX_K   = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_BOX_L   = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_BOX_M   = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_RECIP_K = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_RECIP_L = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_RECIP_M = 3'd5;

    localparam logic CMD_CHAIN  = 1'b0;
    localparam logic CMD_ANCHOR = 1'b1;
endpackage
`default_nettype wire

>>> hdl/tnig_front.sv
// ----------------------------------------------------------------------------
// tnig_front: input capture and queue
// Accept items into a two-entry queue holding command, position and reference.
// ----------------------------------------------------------------------------
`default_nettype none
module tnig_front #(
    parameter int COORD_BITS = 24
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire  [6*COORD_BITS:0]    i_item,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic [6*COORD_BITS:0]    o_item
);
    logic [6*COORD_BITS:0] r_q [2];
    logic                  r_wp, r_rp;
    logic [1:0]            r_cnt;
    logic                  w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

>>> hdl/tnig_back.sv
// ----------------------------------------------------------------------------
// tnig_back: image count and shift sequencer
// Form P, accumulate three dot products, round, then apply box shifts.
// ----------------------------------------------------------------------------
`default_nettype none
module tnig_back #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 13
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire  [2:0]               i_cfg_idx,
    input  wire  [62:0]              i_cfg_data,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire  [6*COORD_BITS:0]    i_item,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic [3*COORD_BITS+24:0] o_res
);
    localparam int CB  = tnig_pkg::COMP_BITS;
    localparam int PW  = COORD_BITS + 1;
    localparam int PRW = PW + CB;
    localparam int DW  = PRW + 2;
    localparam int SH  = FRAC_BITS + tnig_pkg::RECIP_FRAC;
    localparam int VW  = COORD_BITS + CB + 10;
    localparam int BW  = CB + 8;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DOT  = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [62:0] r_box [3];
    logic [62:0] r_rec [3];
    logic signed [COORD_BITS-1:0] r_prev [3];
    logic signed [COORD_BITS-1:0] r_pos [3];
    logic signed [PW-1:0]  r_p [3];
    logic signed [DW-1:0]  r_dot [3];
    logic signed [7:0]     r_cnt [3];
    logic signed [7:0]     r_out_cnt [3];
    logic signed [COORD_BITS-1:0] r_res [3];
    logic [1:0]  r_st;
    logic [1:0]  r_step;
    logic        r_ovf;
    logic        r_out_ovf;
    logic        r_full;

    logic signed [COORD_BITS-1:0] w_pos [3];
    logic signed [COORD_BITS-1:0] w_ref [3];
    logic signed [PRW-1:0] w_prod [3];
    logic signed [7:0]     w_cnt [3];
    logic                  w_covf [3];
    logic signed [VW-1:0]  w_v [3];
    logic signed [COORD_BITS-1:0] w_res [3];
    logic                  w_vovf [3];
    logic                  w_load;

    function automatic logic signed [CB-1:0] comp(input logic [62:0] r, input int j);
        comp = r[j*CB +: CB];
    endfunction

    assign o_ready = (r_st == ST_IDLE);
    assign o_valid = r_full;
    assign o_res = {r_out_ovf, r_out_cnt[2], r_out_cnt[1], r_out_cnt[0],
                    r_res[2], r_res[1], r_res[0]};
    assign w_load = (r_st == ST_OUT) && (!r_full || i_ready);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pos[i] = i_item[1 + i*COORD_BITS +: COORD_BITS];
            w_ref[i] = (i_item[0] == tnig_pkg::CMD_ANCHOR) ?
                       i_item[1 + (3+i)*COORD_BITS +: COORD_BITS] : r_prev[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_prod[i] = PRW'(comp(r_rec[i], int'(r_step))) * PRW'(r_p[r_step]);
        end
    end

    // round half even and clamp each count
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [DW-1:0] mag;
            logic [DW-1:0] q;
            logic [SH-1:0] rem;
            logic          up;
            logic signed [DW:0] sq;
            mag = r_dot[i][DW-1] ? DW'(-r_dot[i]) : DW'(r_dot[i]);
            q   = mag >> SH;
            rem = mag[SH-1:0];
            up  = (rem > {1'b1, {(SH-1){1'b0}}}) ||
                  ((rem == {1'b1, {(SH-1){1'b0}}}) && q[0]);
            q   = q + DW'(up);
            sq  = r_dot[i][DW-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
            w_covf[i] = (sq > 127) || (sq < -128);
            w_cnt[i]  = (sq > 127) ? 8'sd127 : (sq < -128) ? -8'sd128 : sq[7:0];
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            logic signed [BW-1:0] prod;
            w_v[j] = VW'(r_pos[j]);
            for (int i = 0; i < 3; i++) begin
                prod   = BW'(comp(r_box[i], j)) * BW'(r_cnt[i]);
                w_v[j] = w_v[j] + VW'(prod);
            end
            w_vovf[j] = (w_v[j] > VW'(2**(COORD_BITS-1) - 1)) ||
                        (w_v[j] < -VW'(2**(COORD_BITS-1)));
            w_res[j] = (w_v[j] > VW'(2**(COORD_BITS-1) - 1)) ?
                       {1'b0, {(COORD_BITS-1){1'b1}}} :
                       (w_v[j] < -VW'(2**(COORD_BITS-1))) ?
                       {1'b1, {(COORD_BITS-1){1'b0}}} : w_v[j][COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_box[i]  <= '0;
                r_rec[i]  <= '0;
                r_prev[i] <= '0;
            end
            r_st      <= ST_IDLE;
            r_step    <= '0;
            r_full    <= 1'b0;
            r_ovf     <= 1'b0;
            r_out_ovf <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tnig_pkg::REG_BOX_K:   r_box[0] <= i_cfg_data;
                    tnig_pkg::REG_BOX_L:   r_box[1] <= i_cfg_data;
                    tnig_pkg::REG_BOX_M:   r_box[2] <= i_cfg_data;
                    tnig_pkg::REG_RECIP_K: r_rec[0] <= i_cfg_data;
                    tnig_pkg::REG_RECIP_L: r_rec[1] <= i_cfg_data;
                    tnig_pkg::REG_RECIP_M: r_rec[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_load) begin
                r_full <= 1'b1;
            end else if (i_ready) begin
                r_full <= 1'b0;
            end
            case (r_st)
                ST_IDLE: begin
                    if (i_valid && o_ready) begin
                        for (int i = 0; i < 3; i++) begin
                            r_pos[i] <= w_pos[i];
                            r_p[i]   <= PW'(w_pos[i]) - PW'(w_ref[i]);
                            r_dot[i] <= '0;
                        end
                        r_step <= '0;
                        r_st   <= ST_DOT;
                    end
                end
                ST_DOT: begin
                    for (int i = 0; i < 3; i++) begin
                        r_dot[i] <= r_dot[i] + DW'(w_prod[i]);
                    end
                    r_step <= (r_step == 2'd2) ? 2'd0 : r_step + 2'd1;
                    if (r_step == 2'd2) r_st <= ST_ADD;
                end
                ST_ADD: begin
                    for (int i = 0; i < 3; i++) r_cnt[i] <= w_cnt[i];
                    r_ovf <= w_covf[0] | w_covf[1] | w_covf[2];
                    r_st  <= ST_OUT;
                end
                ST_OUT: begin
                    // hold until the previous transaction leaves the output register
                    if (w_load) begin
                        for (int j = 0; j < 3; j++) begin
                            r_res[j]     <= w_res[j];
                            r_prev[j]    <= w_res[j];
                            r_out_cnt[j] <= r_cnt[j];
                        end
                        r_out_ovf <= r_ovf | w_vovf[0] | w_vovf[1] | w_vovf[2];
                        r_st      <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hdl/triclinic_nearest_image_gather_core.sv
// ----------------------------------------------------------------------------
// triclinic_nearest_image_gather_core: minimum-image gather, triclinic box
// Path from input transaction to result: queue, three dot steps, count,
// shift. The back end takes no new item until the last one is done, being
// sequential, with the chain reference taken from the previous result.
// Reset: synchronous active low; registers, queue and prior position clear.
// ----------------------------------------------------------------------------
`default_nettype none
module triclinic_nearest_image_gather_core #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 13
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire  [2:0]              i_cfg_idx,
    input  wire  [62:0]             i_cfg_data,
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    // pos_x, pos_y, pos_z, ref_x, ref_y, ref_z (low to high), zero pad
    input  wire  [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire                     s_axis_tuser, // cmd
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    // out_x, out_y, out_z, shift_k, shift_l, shift_m, overflow, zero pad
    output logic [((3*COORD_BITS+25+7)/8)*8-1:0] m_axis_tdata
);
    localparam int OW = ((3*COORD_BITS+25+7)/8)*8;
    logic                   w_v, w_r;
    logic [6*COORD_BITS:0]  w_item;
    logic [3*COORD_BITS+24:0] w_res;

    tnig_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_item({s_axis_tdata[6*COORD_BITS-1:0], s_axis_tuser}),
        .o_valid(w_v), .i_ready(w_r), .o_item(w_item)
    );

    tnig_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(w_v), .o_ready(w_r), .i_item(w_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = OW'(w_res);
endmodule
`default_nettype wire

>>> tb/gather_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gather_checker: scoreboard for the triclinic nearest-image gather
// Watches the register port and both streams, predicts each gathered
// position from the shadow registers and the chained prior position, and
// compares every result field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module gather_checker (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire  [2:0]   i_cfg_idx,
    input  wire  [62:0]  i_cfg_data,
    input  wire          i_in_valid,
    input  wire          i_in_ready,
    input  wire  [143:0] i_in_data,
    input  wire          i_in_user,
    input  wire          i_out_valid,
    input  wire          i_out_ready,
    input  wire  [103:0] i_out_data,
    output int           o_errors,
    output int           o_pending,
    output int           o_checked,
    output int           o_saturated
);
    typedef struct packed {
        logic        ovf;
        logic [7:0]  m;
        logic [7:0]  l;
        logic [7:0]  k;
        logic [23:0] z;
        logic [23:0] y;
        logic [23:0] x;
    } t_gathered;

    t_gathered   gathered_q[$];
    logic [62:0] shadow_reg[6];
    longint      prior_pos[3];

    function automatic longint comp(logic [62:0] r, int i);
        logic [20:0] c;
        c = r[i*tnig_pkg::COMP_BITS +: tnig_pkg::COMP_BITS];
        return longint'($signed(c));
    endfunction

    function automatic longint round_even30(longint s);
        longint mag;
        longint q;
        longint r;
        mag = (s < 0) ? -s : s;
        q = mag >>> 30;
        r = mag & ((64'sd1 <<< 30) - 1);
        if (r > (64'sd1 <<< 29) || (r == (64'sd1 <<< 29) && q[0]))
            q = q + 1;
        return (s < 0) ? -q : q;
    endfunction

    function automatic t_gathered gather(logic cmd, logic [143:0] d);
        longint    pos[3];
        longint    anchor[3];
        longint    diff[3];
        longint    cnt[3];
        longint    acc;
        logic      ovf;
        t_gathered g;
        ovf = 1'b0;
        for (int j = 0; j < 3; j++) begin
            pos[j]    = longint'($signed(d[j*24 +: 24]));
            anchor[j] = (cmd == tnig_pkg::CMD_ANCHOR) ?
                        longint'($signed(d[(j+3)*24 +: 24])) : prior_pos[j];
            diff[j]   = pos[j] - anchor[j];
        end
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += comp(shadow_reg[3+i], j) * diff[j];
            cnt[i] = round_even30(acc);
            if (cnt[i] > 127) begin cnt[i] = 127; ovf = 1'b1; end
            if (cnt[i] < -128) begin cnt[i] = -128; ovf = 1'b1; end
        end
        for (int j = 0; j < 3; j++) begin
            acc = anchor[j] + diff[j];
            for (int i = 0; i < 3; i++)
                acc += comp(shadow_reg[i], j) * cnt[i];
            if (acc > 8388607) begin acc = 8388607; ovf = 1'b1; end
            if (acc < -8388608) begin acc = -8388608; ovf = 1'b1; end
            prior_pos[j] = acc;
        end
        g.x = prior_pos[0][23:0];
        g.y = prior_pos[1][23:0];
        g.z = prior_pos[2][23:0];
        g.k = cnt[0][7:0];
        g.l = cnt[1][7:0];
        g.m = cnt[2][7:0];
        g.ovf = ovf;
        return g;
    endfunction

    assign o_pending = gathered_q.size();

    always @(posedge i_clk) begin
        t_gathered want;
        t_gathered got;
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) shadow_reg[i] = '0;
            for (int j = 0; j < 3; j++) prior_pos[j] = 0;
            gathered_q.delete();
            o_errors = 0;
            o_checked = 0;
            o_saturated = 0;
        end else begin
            if (i_cfg_we && i_cfg_idx < 3'd6)
                shadow_reg[i_cfg_idx] = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                want = gather(i_in_user, i_in_data);
                if (want.ovf) o_saturated++;
                gathered_q.insert(gathered_q.size(), want);
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[96:0];
                if (gathered_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: unexpected result %h", $realtime, got);
                end else begin
                    want = gathered_q.pop_front();
                    o_checked++;
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                        got.k !== want.k || got.l !== want.l || got.m !== want.m ||
                        got.ovf !== want.ovf) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%0t: mismatch exp x=%h y=%h z=%h k=%h l=%h m=%h ovf=%b",
                                     $realtime, want.x, want.y, want.z, want.k, want.l,
                                     want.m, want.ovf,
                                     "\n    act x=%h y=%h z=%h k=%h l=%h m=%h ovf=%b",
                                     got.x, got.y, got.z, got.k, got.l, got.m, got.ovf);
                    end
                end
            end
        end
    end
endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for triclinic_nearest_image_gather_core
// Runs several box settings (zero, cubic with rounding ties, orthorhombic,
// triclinic, saturating extremes, fully random), some with directed anchor
// and chain items before random ones, under random gaps and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    localparam int LIMIT = 400000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [2:0]    i_cfg_idx = '0;
    logic [62:0]   i_cfg_data = '0;
    logic          s_axis_tvalid = 1'b0;
    wire           s_axis_tready;
    // pos_x, pos_y, pos_z, ref_x, ref_y, ref_z
    logic [143:0]  s_axis_tdata = '0;
    logic          s_axis_tuser = 1'b0; // cmd
    wire           m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    // out_x, out_y, out_z, shift_k, shift_l, shift_m, overflow, pad
    wire  [103:0]  m_axis_tdata;

    int errors, pending, checked, saturated;
    int cycles = 0;
    int sent = 0;
    int anchors = 0;
    int gap_mode = 0;
    bit stall_done = 1'b0;

    triclinic_nearest_image_gather_core u_top (.*);

    gather_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata),
        .o_errors(errors), .o_pending(pending), .o_checked(checked),
        .o_saturated(saturated)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(99);
        if (gap_mode == 0) return 0;
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // receiver back-pressure, with one long hold once the run is under way
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!stall_done && sent > 150) begin
                m_axis_tready <= 1'b0;
                for (int c = 0; c < 300; c++) @(posedge i_clk);
                stall_done = 1'b1;
            end else if (gap_mode == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= (rand_gap() == 0);
            end
        end
    end

    function automatic logic [62:0] vec(int x, int y, int z);
        logic [20:0] a, b, c;
        a = x[20:0];
        b = y[20:0];
        c = z[20:0];
        return {c, b, a};
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [62:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic load_box(logic [62:0] bk, bl, bm, rk, rl, rm);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        write_reg(tnig_pkg::REG_BOX_K, bk);
        write_reg(tnig_pkg::REG_BOX_L, bl);
        write_reg(tnig_pkg::REG_BOX_M, bm);
        write_reg(tnig_pkg::REG_RECIP_K, rk);
        write_reg(tnig_pkg::REG_RECIP_L, rl);
        write_reg(tnig_pkg::REG_RECIP_M, rm);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send(logic cmd, int px, py, pz, rx, ry, rz);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {rz[23:0], ry[23:0], rx[23:0], pz[23:0], py[23:0], px[23:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
        if (cmd == tnig_pkg::CMD_ANCHOR) anchors++;
        gap = rand_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic int near(int base, int span);
        return base + $signed($urandom_range(2 * span)) - span;
    endfunction

    task automatic random_items(int n, int span);
        int rx, ry, rz;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) gap_mode = $urandom_range(3) != 0;
            if ($urandom_range(99) < 15) begin
                send($urandom_range(1), $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
            end else begin
                rx = near(0, 2000000);
                ry = near(0, 2000000);
                rz = near(0, 2000000);
                if ($urandom_range(3) == 0)
                    send(tnig_pkg::CMD_ANCHOR, near(rx, span), near(ry, span),
                         near(rz, span), rx, ry, rz);
                else
                    send(tnig_pkg::CMD_CHAIN, near(rx, span), near(ry, span),
                         near(rz, span), $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero box: chain before any anchor, extremes pass through
        gap_mode = 0;
        send(tnig_pkg::CMD_CHAIN, 1000, -2000, 3000, 8388607, -8388608, 5);
        send(tnig_pkg::CMD_ANCHOR, 8388607, 8388607, 8388607,
             -8388608, -8388608, -8388608);
        send(tnig_pkg::CMD_ANCHOR, -8388608, -8388608, -8388608,
             8388607, 8388607, 8388607);
        send(tnig_pkg::CMD_CHAIN, 0, 0, 0, 0, 0, 0);
        random_items(40, 100000);

        // cubic 4 nm box, rounding ties at half, one and a half and two and a half boxes
        load_box(vec(32768, 0, 0), vec(0, 32768, 0), vec(0, 0, 32768),
                 vec(32768, 0, 0), vec(0, 32768, 0), vec(0, 0, 32768));
        gap_mode = 0;
        send(tnig_pkg::CMD_ANCHOR, 16384, -16384, 49152, 0, 0, 0);
        send(tnig_pkg::CMD_ANCHOR, -49152, 81920, -81920, 0, 0, 0);
        send(tnig_pkg::CMD_CHAIN, 40000, 50000, -70000, 0, 0, 0);
        send(tnig_pkg::CMD_CHAIN, 8000000, -8000000, 1000000, 0, 0, 0);
        random_items(100, 300000);

        // orthorhombic box 5 x 6 x 7 nm
        load_box(vec(40960, 0, 0), vec(0, 49152, 0), vec(0, 0, 57344),
                 vec(26214, 0, 0), vec(0, 21845, 0), vec(0, 0, 18724));
        random_items(100, 600000);

        // triclinic box with skewed edges
        load_box(vec(28672, 0, 0), vec(9830, 24576, 0), vec(-6554, 7373, 22118),
                 vec(36571, -14626, 15711), vec(0, 43691, -14564), vec(0, 0, 48545));
        random_items(100, 400000);

        // largest components: counts and coordinates saturate
        load_box(vec(1048575, 1048575, 1048575), vec(-1048576, -1048576, -1048576),
                 vec(1048575, -1048576, 1048575),
                 vec(1048575, 1048575, 1048575), vec(-1048576, -1048576, -1048576),
                 vec(-1048576, 1048575, -1048576));
        gap_mode = 0;
        send(tnig_pkg::CMD_ANCHOR, 8388607, 8388607, 8388607,
             -8388608, -8388608, -8388608);
        send(tnig_pkg::CMD_ANCHOR, -8388608, 0, 8388607, 8388607, 0, -8388608);
        send(tnig_pkg::CMD_CHAIN, 123456, -654321, 8388607, 0, 0, 0);
        send(tnig_pkg::CMD_ANCHOR, 10, -10, 3, 0, 0, 0);
        random_items(90, 4000000);

        // fully random registers
        load_box(63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
                 63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
                 63'({$urandom, $urandom}), 63'({$urandom, $urandom}));
        random_items(100, 1000000);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d items (%0d anchor, %0d chain) over six box settings.",
                 sent, anchors, sent - anchors);
        $display("Checked %0d results, %0d of them saturated.", checked, saturated);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
